@@ rtl/memory_map_decoder_with_timing_unit_assert.svh @@
// ----------------------------------------------------------------------------
// memory_map_decoder_with_timing_unit_assert.svh
// Assertion macros used by the memory map decoder RTL
// ----------------------------------------------------------------------------
`ifndef MEMORY_MAP_DECODER_WITH_TIMING_UNIT_ASSERT_SVH
`define MEMORY_MAP_DECODER_WITH_TIMING_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define MMD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, quiet during reset
`define MMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/mmd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmd_pkg
// Types and constants of the memory map decoder with access timing
// ----------------------------------------------------------------------------
package mmd_pkg;

  // bus access kinds
  typedef enum logic [1:0] {
    ACT_OPCODE  = 2'd0,
    ACT_OPERAND = 2'd1,
    ACT_READ    = 2'd2,
    ACT_WRITE   = 2'd3
  } action_t;

  // decoded targets
  typedef enum logic [2:0] {
    TGT_RAM  = 3'd0,
    TGT_ROM  = 3'd1,
    TGT_AV   = 3'd2,
    TGT_SPR  = 3'd3,
    TGT_MAP  = 3'd4,
    TGT_DROP = 3'd5
  } target_t;

  // map-control bit positions
  localparam int unsigned MAP_SEQ_DIS = 4;
  localparam int unsigned MAP_VEC_DIS = 3;
  localparam int unsigned MAP_ROM_DIS = 2;
  localparam int unsigned MAP_AV_DIS  = 1;
  localparam int unsigned MAP_SPR_DIS = 0;

  // pages and overlay offsets
  localparam logic [7:0]  PAGE_SPR     = 8'hfc;
  localparam logic [7:0]  PAGE_AV      = 8'hfd;
  localparam logic [7:0]  PAGE_ROM_LO  = 8'hfe;
  localparam logic [7:0]  PAGE_TOP     = 8'hff;
  localparam logic [8:0]  OFF_RAM_BYTE = 9'h1f8;
  localparam logic [8:0]  OFF_MAP_REG  = 9'h1f9;
  localparam logic [8:0]  OFF_VECTOR   = 9'h1fa;
  localparam logic [6:0]  OVERLAY_BASE = 7'h7f;
  localparam logic [15:0] ADDR_MAP_REG = 16'hfff9;
  localparam logic [15:0] ADDR_SLOW    = 16'hff80;
  localparam logic [3:0]  READBACK_HI  = 4'hf;

  // cycle costs
  localparam logic [5:0] COST_NONE = 6'd0;
  localparam logic [5:0] COST_FAST = 6'd4;
  localparam logic [5:0] COST_STD  = 6'd5;
  localparam logic [5:0] COST_SLOW = 6'd50;

  // decoder state
  typedef struct packed {
    logic [4:0] map_bits;
    logic       lp_valid;
    logic [7:0] lp_num;
  } state_t;

  // one decoded result
  typedef struct packed {
    target_t     target;
    logic [15:0] phys_address;
    logic [7:0]  read_data;
    logic [5:0]  cycle_cost;
  } result_t;

endpackage

@@ rtl/mmd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmd_in_if / mmd_out_if
// Valid/ready channels for bus accesses and decoded results
// ----------------------------------------------------------------------------
interface mmd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, action, address, write_data, input ready);
  modport sink   (input valid, action, address, write_data, output ready);
endinterface

interface mmd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [15:0] phys_address;
  logic [7:0]  read_data;
  logic [5:0]  cycle_cost;

  modport source (output valid, target, phys_address, read_data, cycle_cost, input ready);
  modport sink   (input valid, target, phys_address, read_data, cycle_cost, output ready);
endinterface

@@ rtl/memory_map_decoder_with_timing_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_map_decoder_with_timing_unit
// Decodes processor bus accesses to RAM, ROM overlay, peripherals or the
// map-control register and reports the cycle cost of each access
// ----------------------------------------------------------------------------
// channel   | direction | payload
// in_bus    | sink      | action, address, write_data
// out_bus   | source    | target, phys_address, read_data, cycle_cost
//
// an accepted transaction passes through the input register and then the result
//   register before it leaves on out_bus
// throughput: one transaction per cycle while out_bus.ready is high; decode is one
//   combinational pass between the input register and the result register
// map bits and page tracker update as a transaction moves into the result
//   register, so each transaction sees the state left by the one before
// reset clears map bits, page tracker and both valid flags
// a stalled result holds its register; the input stage still fills behind it
// ----------------------------------------------------------------------------
`include "memory_map_decoder_with_timing_unit_assert.svh"

module memory_map_decoder_with_timing_unit (
  input  logic clk,
  input  logic rst_n,
  mmd_in_if.sink    in_bus,
  mmd_out_if.source out_bus
);

  logic              s1_valid_r;
  logic [1:0]        s1_action_r;
  logic [15:0]       s1_address_r;
  logic [7:0]        s1_wdata_r;
  mmd_pkg::state_t   state_r;
  mmd_pkg::state_t   state_nxt;
  mmd_pkg::result_t  dec_res;
  logic              out_valid_r;
  mmd_pkg::result_t  out_res_r;
  logic              s1_adv;
  logic              in_take;

  // handshake
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || s1_adv;
  assign in_take      = in_bus.valid && in_bus.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r  <= in_bus.action;
      s1_address_r <= in_bus.address;
      s1_wdata_r   <= in_bus.write_data;
    end
  end

  // decode
  mmd_decode u_decode (
    .action     (s1_action_r),
    .address    (s1_address_r),
    .write_data (s1_wdata_r),
    .st         (state_r),
    .st_nxt     (state_nxt),
    .res        (dec_res)
  );

  // map bits and page tracker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= dec_res;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.target       = out_res_r.target;
  assign out_bus.phys_address = out_res_r.phys_address;
  assign out_bus.read_data    = out_res_r.read_data;
  assign out_bus.cycle_cost   = out_res_r.cycle_cost;

  // assertions
  `MMD_ASSERT_SAME(a_stall_blocks_input, clk, rst_n,
    s1_valid_r && out_valid_r && !out_bus.ready, !in_bus.ready)
  `MMD_ASSERT_SAME(a_fast_needs_hit, clk, rst_n,
    s1_adv && (dec_res.cycle_cost == mmd_pkg::COST_FAST),
    state_r.lp_valid && !state_r.map_bits[mmd_pkg::MAP_SEQ_DIS])
  `MMD_ASSERT_SAME(a_periph_free, clk, rst_n,
    s1_adv && ((dec_res.target == mmd_pkg::TGT_AV) || (dec_res.target == mmd_pkg::TGT_SPR)),
    dec_res.cycle_cost == mmd_pkg::COST_NONE)
  `MMD_ASSERT_NEXT(a_data_access_forgets_page, clk, rst_n,
    s1_adv && ((s1_action_r == mmd_pkg::ACT_READ) || (s1_action_r == mmd_pkg::ACT_WRITE)),
    !state_r.lp_valid)

endmodule

@@ rtl/mmd_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmd_decode
// Address decode, overlay mapping, cycle cost and next map/page state
// ----------------------------------------------------------------------------
module mmd_decode (
  input  logic [1:0]      action,
  input  logic [15:0]     address,
  input  logic [7:0]      write_data,
  input  mmd_pkg::state_t st,
  output mmd_pkg::state_t st_nxt,
  output mmd_pkg::result_t res
);

  logic [7:0] page;
  logic [8:0] off;
  logic       fetch;
  logic       write;
  logic       overlay;
  logic       spr;
  logic       av;
  logic       to_ram;
  logic       page_hit;

  // access classification
  assign page  = address[15:8];
  assign off   = address[8:0];
  assign fetch = (action == mmd_pkg::ACT_OPCODE) || (action == mmd_pkg::ACT_OPERAND);
  assign write = (action == mmd_pkg::ACT_WRITE);

  assign overlay = (page == mmd_pkg::PAGE_TOP) ||
                   ((page == mmd_pkg::PAGE_ROM_LO) && !st.map_bits[mmd_pkg::MAP_ROM_DIS]);
  assign spr = (page == mmd_pkg::PAGE_SPR) && !st.map_bits[mmd_pkg::MAP_SPR_DIS];
  assign av  = (page == mmd_pkg::PAGE_AV) && !st.map_bits[mmd_pkg::MAP_AV_DIS];

  assign page_hit = st.lp_valid && (st.lp_num == page);

  // overlay byte goes to ram or rom
  always_comb begin
    if (off >= mmd_pkg::OFF_VECTOR) begin
      to_ram = st.map_bits[mmd_pkg::MAP_VEC_DIS];
    end else if (off < mmd_pkg::OFF_RAM_BYTE) begin
      to_ram = st.map_bits[mmd_pkg::MAP_ROM_DIS];
    end else begin
      to_ram = (off == mmd_pkg::OFF_RAM_BYTE);
    end
  end

  // result and next state
  always_comb begin
    st_nxt           = st;
    res.target       = mmd_pkg::TGT_RAM;
    res.phys_address = address;
    res.read_data    = '0;
    res.cycle_cost   = mmd_pkg::COST_STD;

    if (spr || av) begin
      res.target     = spr ? mmd_pkg::TGT_SPR : mmd_pkg::TGT_AV;
      res.cycle_cost = mmd_pkg::COST_NONE;
      if (action != mmd_pkg::ACT_OPCODE) begin
        st_nxt.lp_valid = 1'b0;
      end
    end else if (overlay) begin
      if (off == mmd_pkg::OFF_MAP_REG) begin
        res.target       = mmd_pkg::TGT_MAP;
        res.phys_address = mmd_pkg::ADDR_MAP_REG;
        if (write) begin
          st_nxt.map_bits = {write_data[7], write_data[3:0]};
        end else begin
          res.read_data = {mmd_pkg::READBACK_HI, st.map_bits[3:0]};
        end
      end else if (to_ram) begin
        res.target       = mmd_pkg::TGT_RAM;
        res.phys_address = {mmd_pkg::OVERLAY_BASE, off};
      end else begin
        res.target       = write ? mmd_pkg::TGT_DROP : mmd_pkg::TGT_ROM;
        res.phys_address = {7'd0, off};
      end
      // overlay fetches leave the page tracker alone
      if (fetch) begin
        res.cycle_cost = (address == mmd_pkg::ADDR_SLOW) ? mmd_pkg::COST_SLOW
                                                         : mmd_pkg::COST_STD;
      end else begin
        st_nxt.lp_valid = 1'b0;
      end
    end else begin
      // plain ram with same-page fetch tracking
      if (fetch) begin
        if (page_hit) begin
          res.cycle_cost = st.map_bits[mmd_pkg::MAP_SEQ_DIS] ? mmd_pkg::COST_STD
                                                             : mmd_pkg::COST_FAST;
        end else begin
          st_nxt.lp_valid = 1'b1;
          st_nxt.lp_num   = page;
        end
      end else begin
        st_nxt.lp_valid = 1'b0;
      end
    end
  end

endmodule
